// File: hw/rtl/pef_pkg.sv
package pef_pkg;

    // field widths of the stream payloads
    localparam int KIND_W     = 8;
    localparam int ARG_W      = 32;
    localparam int COUNT_W    = 7;
    localparam int QMAX_W     = 7;
    localparam int TLIM_W     = 9;
    localparam int CFG_W      = 9;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 152;

    // configuration reset values
    localparam logic [QMAX_W-1:0] QMAX_RESET = 7'd64;
    localparam logic [TLIM_W-1:0] TLIM_RESET = 9'd256;

    // opcodes carried in the input tuser
    localparam logic OP_SEND = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // configuration register indexes
    localparam logic REG_QUEUE_MAX  = 1'b0;
    localparam logic REG_TYPE_LIMIT = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_QUEUED    = 3'd0,
        ST_BADTYPE   = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_FULL      = 3'd3,
        ST_TAKEN     = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_FINISH = 2'b10
    } state_t;

    // one stored event, kind in the lowest bits
    typedef struct packed {
        logic [ARG_W-1:0]  stamp;
        logic [ARG_W-1:0]  arg_c;
        logic [ARG_W-1:0]  arg_b;
        logic [ARG_W-1:0]  arg_a;
        logic [KIND_W-1:0] kind;
    } event_t;

    // controller to datapath
    typedef struct packed {
        logic issue;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_valid;
    } stat_t;

endpackage

// File: hw/rtl/pef_ctrl.sv
module pef_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           m_tready,
    input  pef_pkg::stat_t stat,
    output pef_pkg::cmd_t  cmd
);
    import pef_pkg::*;

    state_t state_reg;
    state_t state_next;

    // handshake decode
    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.issue  = s_tvalid && s_tready;
    assign cmd.commit = (state_reg == S_FINISH) && (!stat.out_valid || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.issue)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a result is always handed to the output register before the next transaction
    a_commit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (s_tready && !cmd.commit))
        else $error("commit did not return to idle");

    a_issue_waits_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> !s_tready)
        else $error("transaction accepted while a result was pending");

    a_commit_only_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !cmd.issue)
        else $error("issue and commit in the same cycle");

endmodule

// File: hw/rtl/pef_datapath.sv
module pef_datapath #(
    parameter int POOL_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pef_pkg::cmd_t                    cmd,
    output pef_pkg::stat_t                   stat,
    input  logic [pef_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pef_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [2:0]                       m_tuser,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [pef_pkg::CFG_W-1:0]        cfg_data
);
    import pef_pkg::*;

    localparam int IW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int XW = CW + COUNT_W;
    localparam logic [IW-1:0] LAST_SLOT = IW'(POOL_DEPTH - 1);

    // slot memories
    logic [IW-1:0] link_mem [POOL_DEPTH];
    event_t        pay_mem  [POOL_DEPTH];
    logic [IW-1:0] link_rd_reg;
    event_t        pay_rd_reg;

    // pointers and counts
    logic [IW-1:0] free_top_reg,    free_top_next;
    logic [CW-1:0] free_total_reg,  free_total_next;
    logic [IW-1:0] queue_first_reg, queue_first_next;
    logic [IW-1:0] queue_last_reg,  queue_last_next;
    logic [CW-1:0] queue_total_reg, queue_total_next;
    logic [CW-1:0] wmark_reg,       wmark_next;

    // configuration
    logic [QMAX_W-1:0] qmax_reg;
    logic [TLIM_W-1:0] tlim_reg;

    // pending transaction
    logic          upd_reg;
    logic          pend_pop_reg;
    logic          pend_take_reg;
    status_t       status_reg;
    logic          fresh_reg;
    logic [IW-1:0] fresh_link_reg;

    // output register
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [2:0]            m_user_reg;

    // decode
    event_t        ev_in;
    status_t       st_dec;
    logic          do_pop;
    logic          do_take;
    logic          wr_payload;
    logic          link_we;
    logic [IW-1:0] link_wa;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] rd_succ;
    logic          rd_fresh;
    logic [IW-1:0] link_val;
    logic [XW-1:0] qtot_ext;
    logic [XW-1:0] qmax_ext;
    logic [XW-1:0] qnow_ext;
    logic [XW-1:0] fnow_ext;
    logic          kind_ok;
    logic          pool_empty;
    logic          queue_full;

    assign ev_in      = event_t'(s_tdata);
    assign qtot_ext   = XW'(queue_total_reg);
    assign qmax_ext   = XW'(qmax_reg);
    assign kind_ok    = {1'b0, ev_in.kind} < tlim_reg;
    assign pool_empty = (free_total_reg == '0);
    assign queue_full = (qtot_ext >= qmax_ext);
    assign rd_addr    = (s_tuser == OP_TAKE) ? queue_first_reg : free_top_reg;
    assign rd_succ    = (rd_addr == LAST_SLOT) ? '0 : rd_addr + 1'b1;
    assign rd_fresh   = (CW'(rd_addr) >= wmark_reg);
    assign link_wa    = (s_tuser == OP_TAKE) ? queue_first_reg : queue_last_reg;

    // item decision
    always_comb
    begin
        st_dec     = ST_EMPTY;
        do_pop     = 1'b0;
        do_take    = 1'b0;
        wr_payload = 1'b0;
        link_we    = 1'b0;
        if (s_tuser == OP_SEND)
        begin
            if (!kind_ok)
            begin
                st_dec = ST_BADTYPE;
            end
            else if (pool_empty)
            begin
                st_dec = ST_EXHAUSTED;
            end
            else
            begin
                wr_payload = cmd.issue;
                if (queue_full)
                begin
                    st_dec = ST_FULL;
                end
                else
                begin
                    st_dec  = ST_QUEUED;
                    do_pop  = cmd.issue;
                    link_we = cmd.issue && (queue_total_reg != '0);
                end
            end
        end
        else
        begin
            if (queue_total_reg != '0)
            begin
                st_dec  = ST_TAKEN;
                do_take = cmd.issue;
                link_we = cmd.issue;
            end
        end
    end

    // link followed in the cycle after a pop or take
    assign link_val = fresh_reg ? fresh_link_reg : link_rd_reg;

    // pointer and count updates
    always_comb
    begin
        free_top_next    = free_top_reg;
        free_total_next  = free_total_reg;
        queue_first_next = queue_first_reg;
        queue_last_next  = queue_last_reg;
        queue_total_next = queue_total_reg;
        wmark_next       = wmark_reg;
        if (do_pop)
        begin
            free_total_next  = free_total_reg - 1'b1;
            queue_last_next  = free_top_reg;
            queue_total_next = queue_total_reg + 1'b1;
            if (queue_total_reg == '0)
            begin
                queue_first_next = free_top_reg;
            end
            if (rd_fresh)
            begin
                wmark_next = wmark_reg + 1'b1;
            end
        end
        if (do_take)
        begin
            free_top_next    = queue_first_reg;
            free_total_next  = free_total_reg + 1'b1;
            queue_total_next = queue_total_reg - 1'b1;
        end
        if (upd_reg && pend_pop_reg)
        begin
            free_top_next = link_val;
        end
        if (upd_reg && pend_take_reg)
        begin
            queue_first_next = link_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_top_reg    <= '0;
            free_total_reg  <= CW'(POOL_DEPTH);
            queue_first_reg <= '0;
            queue_last_reg  <= '0;
            queue_total_reg <= '0;
            wmark_reg       <= '0;
        end
        else
        begin
            free_top_reg    <= free_top_next;
            free_total_reg  <= free_total_next;
            queue_first_reg <= queue_first_next;
            queue_last_reg  <= queue_last_next;
            queue_total_reg <= queue_total_next;
            wmark_reg       <= wmark_next;
        end
    end

    // link memory, read before write at the same address
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            link_rd_reg <= link_mem[rd_addr];
        end
        if (link_we)
        begin
            link_mem[link_wa] <= do_take ? free_top_reg : free_top_reg;
        end
    end

    // event payload memory
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            pay_rd_reg <= pay_mem[rd_addr];
        end
        if (wr_payload)
        begin
            pay_mem[free_top_reg] <= ev_in;
        end
    end

    // pending transaction control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_reg       <= 1'b0;
            pend_pop_reg  <= 1'b0;
            pend_take_reg <= 1'b0;
            status_reg    <= ST_QUEUED;
        end
        else
        begin
            upd_reg <= cmd.issue;
            if (cmd.issue)
            begin
                pend_pop_reg  <= do_pop;
                pend_take_reg <= do_take;
                status_reg    <= st_dec;
            end
        end
    end

    // implicit reset link for slots never written
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            fresh_reg      <= rd_fresh;
            fresh_link_reg <= rd_succ;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qmax_reg <= QMAX_RESET;
            tlim_reg <= TLIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_QUEUE_MAX:  qmax_reg <= cfg_data[QMAX_W-1:0];
                REG_TYPE_LIMIT: tlim_reg <= cfg_data[TLIM_W-1:0];
                default:        qmax_reg <= qmax_reg;
            endcase
        end
    end

    // result assembly
    assign qnow_ext = XW'(queue_total_reg);
    assign fnow_ext = XW'(free_total_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            m_user_reg <= status_reg;
            m_data_reg <= {2'b00, fnow_ext[COUNT_W-1:0], qnow_ext[COUNT_W-1:0],
                           (status_reg == ST_TAKEN) ? pay_rd_reg : event_t'('0)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid       = m_valid_reg;
    assign m_tdata        = m_data_reg;
    assign m_tuser        = m_user_reg;
    assign stat.out_valid = m_valid_reg;

    // every slot is free or queued, never both
    a_slot_conservation: assert property (@(posedge clk) disable iff (!rst_n)
        (XW'(queue_total_reg) + XW'(free_total_reg)) <= XW'(POOL_DEPTH))
        else $error("slot counts exceed the pool");

    // the free top is a reused slot or the first untouched one
    a_free_top_watermark: assert property (@(posedge clk) disable iff (!rst_n)
        (free_total_reg != '0 && !upd_reg) |-> (CW'(free_top_reg) <= wmark_reg))
        else $error("free top beyond the fill watermark");

    // a pointer update follows each accepted transaction exactly once
    a_update_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> (upd_reg && !cmd.issue))
        else $error("pointer update missing after transaction");

    // a committed result shows up on the output
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("committed result not presented");

endmodule

// File: hw/rtl/pooled_event_fifo_unit.sv
// Event queue on a pool of POOL_DEPTH slots: free slots form a stack, queued
// events a linked FIFO through the same slots.
// Input channel s_*: s_tuser is the opcode (send or take), s_tdata the event.
// Output channel m_*: one result transaction per input transaction, in order;
// m_tuser is the status code, m_tdata the taken event and the counts.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 queue_max, 1 type_limit) at the clock edge; the user must write only
// while idle; the block does not enforce it. A result passes through the FINISH
// state into the output register (m_tvalid), which must be free to take it.
// No new transaction enters before the current one has finished: the slot link
// memory read is registered and the pointer update follows in the next cycle.
// The output register lets a new transaction enter while a result waits; if a
// second result is ready before the first is taken, s_tready stays low until
// m_tready drains the output.
// Reset (rst_n low, asynchronous) empties the queue and frees every slot at
// once; untouched slots follow their reset links through a fill watermark, so
// no clearing pass is needed. Configuration returns to 64 and 256.
module pooled_event_fifo_unit #(
    parameter int POOL_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // event_kind[7:0], arg_a[39:8], arg_b[71:40], arg_c[103:72], stamp[135:104]
    input  logic [pef_pkg::IN_DATA_W-1:0]   s_tdata,
    // opcode[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_kind[7:0], out_a[39:8], out_b[71:40], out_c[103:72], out_stamp[135:104],
    // queued_now[142:136], free_now[149:143], zero[151:150]
    output logic [pef_pkg::OUT_DATA_W-1:0]  m_tdata,
    // status[2:0]
    output logic [2:0]                      m_tuser,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [pef_pkg::CFG_W-1:0]       cfg_data
);
    import pef_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencing of each transaction
    pef_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // slot memories, pointers and result register
    pef_datapath #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// File: tb/event_queue_checker.sv
`timescale 1ns / 1ps

module event_queue_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // event_kind[7:0], arg_a[39:8], arg_b[71:40], arg_c[103:72], stamp[135:104]
    input  logic [pef_pkg::IN_DATA_W-1:0]  s_tdata,
    // opcode[0]
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // out_kind[7:0], out_a[39:8], out_b[71:40], out_c[103:72], out_stamp[135:104],
    // queued_now[142:136], free_now[149:143], zero[151:150]
    input  logic [pef_pkg::OUT_DATA_W-1:0] m_tdata,
    // status[2:0]
    input  logic [2:0]                     m_tuser,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [pef_pkg::CFG_W-1:0]      cfg_data,
    output int                             fail_count,
    output int                             pending,
    output int                             results_checked,
    output logic [7:0]                     status_seen
);

    import pef_pkg::*;

    localparam int POOL_SLOTS = 64;
    localparam int IDX_W      = 6;

    // one predicted result transaction
    typedef struct packed {
        status_t           status;
        logic [KIND_W-1:0] kind;
        logic [ARG_W-1:0]  a;
        logic [ARG_W-1:0]  b;
        logic [ARG_W-1:0]  c;
        logic [ARG_W-1:0]  stamp;
        logic [COUNT_W-1:0] queued;
        logic [COUNT_W-1:0] free;
    } event_outcome_t;

    // slot pool contents and links
    logic [KIND_W-1:0] slot_kind  [POOL_SLOTS];
    logic [ARG_W-1:0]  slot_a     [POOL_SLOTS];
    logic [ARG_W-1:0]  slot_b     [POOL_SLOTS];
    logic [ARG_W-1:0]  slot_c     [POOL_SLOTS];
    logic [ARG_W-1:0]  slot_stamp [POOL_SLOTS];
    logic [IDX_W-1:0]  slot_next  [POOL_SLOTS];

    // free stack and event list pointers
    logic [IDX_W-1:0]  free_head;
    logic [IDX_W-1:0]  list_head;
    logic [IDX_W-1:0]  list_tail;
    int                free_slots;
    int                events_held;
    logic [QMAX_W-1:0] max_events;
    logic [TLIM_W-1:0] kind_limit;

    event_outcome_t    queued_outcomes [$];
    event_outcome_t    want;
    event_t            got_event;
    int                errors;
    int                checked;
    logic [7:0]        seen;
    int                i;

    // send or take one event, update the pool and give the outcome
    function automatic event_outcome_t step_event_queue(input logic op, input event_t ev);
        event_outcome_t r;
        logic [IDX_W-1:0] slot;
        r = '0;
        if (op == OP_SEND) begin
            if ({1'b0, ev.kind} >= kind_limit) begin
                r.status = ST_BADTYPE;
            end else if (free_slots == 0) begin
                r.status = ST_EXHAUSTED;
            end else begin
                slot = free_head;
                free_head = slot_next[slot];
                free_slots--;
                slot_kind[slot]  = ev.kind;
                slot_a[slot]     = ev.arg_a;
                slot_b[slot]     = ev.arg_b;
                slot_c[slot]     = ev.arg_c;
                slot_stamp[slot] = ev.stamp;
                if (events_held >= int'(max_events)) begin
                    // slot goes straight back onto the free stack
                    slot_next[slot] = free_head;
                    free_head = slot;
                    free_slots++;
                    r.status = ST_FULL;
                end else begin
                    if (events_held == 0)
                        list_head = slot;
                    else
                        slot_next[list_tail] = slot;
                    list_tail = slot;
                    events_held++;
                    r.status = ST_QUEUED;
                end
            end
        end else begin
            if (events_held == 0) begin
                r.status = ST_EMPTY;
            end else begin
                slot = list_head;
                list_head = slot_next[slot];
                events_held--;
                r.kind  = slot_kind[slot];
                r.a     = slot_a[slot];
                r.b     = slot_b[slot];
                r.c     = slot_c[slot];
                r.stamp = slot_stamp[slot];
                slot_next[slot] = free_head;
                free_head = slot;
                free_slots++;
                r.status = ST_TAKEN;
            end
        end
        r.queued = COUNT_W'(events_held);
        r.free   = COUNT_W'(free_slots);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: result %0d %s mismatch, expected %0h, actual %0h",
                     $time, checked, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (i = 0; i < POOL_SLOTS; i++)
                slot_next[i] = IDX_W'(i + 1);
            free_head   = '0;
            list_head   = '0;
            list_tail   = '0;
            free_slots  = POOL_SLOTS;
            events_held = 0;
            max_events  = QMAX_RESET;
            kind_limit  = TLIM_RESET;
            queued_outcomes.delete();
            errors  = 0;
            checked = 0;
            seen    = '0;
        end else begin
            // result transaction against the oldest prediction
            if (m_tvalid && m_tready) begin
                seen[m_tuser] = 1'b1;
                if (queued_outcomes.size() == 0) begin
                    errors++;
                    $display("%0t: result with status %0d arrived, none expected",
                             $time, m_tuser);
                end else begin
                    want = queued_outcomes.pop_front();
                    got_event = event_t'(m_tdata[IN_DATA_W-1:0]);
                    check_field("status", 32'(want.status), 32'(m_tuser));
                    check_field("out_kind", 32'(want.kind), 32'(got_event.kind));
                    check_field("out_a", want.a, got_event.arg_a);
                    check_field("out_b", want.b, got_event.arg_b);
                    check_field("out_c", want.c, got_event.arg_c);
                    check_field("out_stamp", want.stamp, got_event.stamp);
                    check_field("queued_now", 32'(want.queued), 32'(m_tdata[142:136]));
                    check_field("free_now", 32'(want.free), 32'(m_tdata[149:143]));
                end
                checked++;
            end
            // register writes
            if (cfg_we) begin
                if (cfg_index == REG_QUEUE_MAX)
                    max_events = cfg_data[QMAX_W-1:0];
                else
                    kind_limit = cfg_data[TLIM_W-1:0];
            end
            // input transaction
            if (s_tvalid && s_tready)
                queued_outcomes.push_back(step_event_queue(s_tuser, event_t'(s_tdata)));
        end
        fail_count      <= errors;
        pending         <= queued_outcomes.size();
        results_checked <= checked;
        status_seen     <= seen;
    end

endmodule

// File: tb/tb_pooled_event_fifo_unit.sv
`timescale 1ns / 1ps

module tb_pooled_event_fifo_unit;

    import pef_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = OP_SEND;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = REG_QUEUE_MAX;
    logic [CFG_W-1:0]      cfg_data  = '0;

    int         fail_count;
    int         pending;
    int         results_checked;
    logic [7:0] status_seen;

    int tx_idle_pct = 27;
    int rx_idle_pct = 85;
    int cur_qmax    = 64;
    int cur_tlim    = 256;
    int items_sent  = 0;
    int reg_writes  = 0;
    int quiet       = 0;
    int phase, sub, left, n, m, k, r;

    pooled_event_fifo_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    event_queue_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .status_seen     (status_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // stop when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    // one input transaction, with random gaps before it
    task automatic drive_item(input logic op, input logic [7:0] kind,
                              input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] stamp);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {stamp, c, b, a, kind};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // mostly kinds that pass the current limit
    function automatic logic [7:0] pick_kind();
        int lim;
        lim = cur_tlim;
        if (lim > 0 && $urandom_range(0, 9) != 0)
            return 8'($urandom_range(0, lim - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random();
        drive_item(OP_SEND, pick_kind(), $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic take_random();
        drive_item(OP_TAKE, 8'($urandom), $urandom, $urandom, $urandom, $urandom);
    endtask

    // hold off until every result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        reg_writes++;
        if (idx == REG_QUEUE_MAX)
            cur_qmax = val;
        else
            cur_tlim = val;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty take, field extremes, fifo order
        take_random();
        drive_item(OP_SEND, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0);
        drive_item(OP_SEND, 8'hff, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'hffffffff);
        drive_item(OP_SEND, 8'h5a, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'h1);
        repeat (4) take_random();

        // bad type with every kind rejected
        write_reg(REG_TYPE_LIMIT, 0);
        drive_item(OP_SEND, 8'h00, 32'h1, 32'h2, 32'h3, 32'h4);

        // zero queue limit turns every valid send away
        write_reg(REG_TYPE_LIMIT, 256);
        write_reg(REG_QUEUE_MAX, 0);
        send_random();
        take_random();

        // small queue limit: queue full, then drain
        write_reg(REG_QUEUE_MAX, 2);
        repeat (3) send_random();
        repeat (2) take_random();

        // kind right at and right below the limit
        write_reg(REG_TYPE_LIMIT, 200);
        drive_item(OP_SEND, 8'd200, $urandom, $urandom, $urandom, $urandom);
        drive_item(OP_SEND, 8'd199, $urandom, $urandom, $urandom, $urandom);
        take_random();

        // random sequences under several settings and idle patterns
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 27; rx_idle_pct = 85; end
                1: begin tx_idle_pct = 85; rx_idle_pct = 27; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (sub = 0; sub < 4; sub++) begin
                case (sub)
                    0: begin
                        write_reg(REG_QUEUE_MAX, 64);
                        write_reg(REG_TYPE_LIMIT, 256);
                    end
                    1: begin
                        write_reg(REG_QUEUE_MAX, $urandom_range(1, 63));
                        write_reg(REG_TYPE_LIMIT, $urandom_range(1, 255));
                    end
                    2: begin
                        write_reg(REG_QUEUE_MAX, $urandom_range(0, 4));
                        write_reg(REG_TYPE_LIMIT, $urandom_range(1, 8));
                    end
                    default: begin
                        write_reg(REG_QUEUE_MAX, 64);
                        write_reg(REG_TYPE_LIMIT, $urandom_range(128, 256));
                    end
                endcase
                left = 36;
                // fill the whole pool past its last slot, then take 20 events back
                if (phase == 0 && sub == 0) begin
                    for (k = 0; k < 66; k++)
                        drive_item(OP_SEND, 8'($urandom_range(0, 255)), $urandom,
                                   $urandom, $urandom, $urandom);
                    for (k = 0; k < 20; k++)
                        take_random();
                    left = 0;
                end
                while (left > 0) begin
                    r = $urandom_range(0, 9);
                    if (r < 4) begin
                        // burst of sends followed by takes
                        n = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 70)
                                                        : $urandom_range(1, 12);
                        m = $urandom_range(1, n + 2);
                        for (k = 0; k < n; k++)
                            send_random();
                        for (k = 0; k < m; k++)
                            take_random();
                        left -= n + m;
                    end else if (r < 8) begin
                        // interleaved sends and takes
                        n = $urandom_range(1, 10);
                        for (k = 0; k < n; k++) begin
                            if ($urandom_range(0, 1) == 0)
                                send_random();
                            else
                                take_random();
                        end
                        left -= n;
                    end else begin
                        // any kind at all
                        n = $urandom_range(1, 6);
                        for (k = 0; k < n; k++)
                            drive_item(OP_SEND, 8'($urandom_range(0, 255)), $urandom,
                                       $urandom, $urandom, $urandom);
                        left -= n;
                    end
                    if ($urandom_range(0, 15) == 0)
                        wait_drained();
                end
            end
        end

        wait_drained();
        repeat (6) @(posedge clk);

        $display("ran %0d input transactions and %0d register writes, %0d results checked",
                 items_sent, reg_writes, results_checked);
        $display("status codes returned (one bit per code, queued lowest): %b",
                 status_seen[5:0]);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
